// File: design/next_permutation_stepper_core_assert.svh
// Assertion macros shared by the stepper modules.
// Each macro expects clk and rst_n in scope.
`ifndef NEXT_PERMUTATION_STEPPER_CORE_ASSERT_SVH
`define NEXT_PERMUTATION_STEPPER_CORE_ASSERT_SVH

// Same-cycle implication.
`define NPS_ASSERT_THEN(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define NPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/nps_pkg.sv
`timescale 1ns / 1ps

package nps_pkg;

  localparam int DIGIT_W     = 4;
  localparam int PACK_DIGITS = 10;
  localparam int PACK_W      = PACK_DIGITS * DIGIT_W;
  localparam int TOTAL_W     = 4;
  localparam int STEP_W      = 22;
  localparam int CFG_DW      = 32;
  localparam int CFG_AW      = 3;
  localparam int UPC_W       = 4;
  localparam int UCODE_DEPTH = 14;

  localparam logic [CFG_AW-3:0] REG_MAX_STEPS = '0;

  typedef struct packed {
    logic               action;
    logic [DIGIT_W-1:0] digit;
    logic               first_digit;
  } in_item_t;

  typedef struct packed {
    logic               stepped;
    logic [PACK_W-1:0]  permutation_packed;
    logic [TOTAL_W-1:0] digit_total;
  } out_item_t;

  localparam logic ACTION_LOAD    = 1'b0;
  localparam logic ACTION_ADVANCE = 1'b1;

  typedef enum logic [2:0] {
    COND_NEXT     = 3'd0,
    COND_ALWAYS   = 3'd1,
    COND_SKIP     = 3'd2,
    COND_IDX_ZERO = 3'd3,
    COND_NOT_RISE = 3'd4,
    COND_GT       = 3'd5,
    COND_LO_GE_HI = 3'd6
  } cond_e;

  typedef enum logic [2:0] {
    RD_LAST   = 3'd0,
    RD_IDX_M1 = 3'd1,
    RD_IDX    = 3'd2,
    RD_LO     = 3'd3,
    RD_HI     = 3'd4
  } rd_sel_e;

  typedef enum logic [1:0] {
    IDX_HOLD = 2'd0,
    IDX_LAST = 2'd1,
    IDX_DEC  = 2'd2
  } idx_op_e;

  typedef enum logic [2:0] {
    WR_NONE  = 3'd0,
    WR_IDX_A = 3'd1,
    WR_PIV_B = 3'd2,
    WR_HI_A  = 3'd3,
    WR_LO_B  = 3'd4
  } wr_sel_e;

  typedef enum logic [1:0] {
    FIN_NONE = 2'd0,
    FIN_NO   = 2'd1,
    FIN_YES  = 2'd2
  } fin_e;

  typedef struct packed {
    cond_e            cond;
    logic [UPC_W-1:0] target;
    rd_sel_e          rd_sel;
    idx_op_e          idx_op;
    logic             load_a;
    logic             load_b;
    logic             load_piv;
    logic             init_lohi;
    logic             step_lohi;
    wr_sel_e          wr_sel;
    fin_e             fin;
  } ucode_word_t;

  typedef struct packed {
    logic skip;
    logic idx_zero;
    logic not_rise;
    logic gt;
    logic lo_ge_hi;
  } cond_flags_t;

  typedef struct packed {
    logic               en;
    logic               first;
    logic [DIGIT_W-1:0] digit;
  } load_req_t;

  localparam logic [UPC_W-1:0] LBL_START   = 4'd0;
  localparam logic [UPC_W-1:0] LBL_SCAN    = 4'd1;
  localparam logic [UPC_W-1:0] LBL_FIND    = 4'd4;
  localparam logic [UPC_W-1:0] LBL_SWAP    = 4'd6;
  localparam logic [UPC_W-1:0] LBL_REV     = 4'd8;
  localparam logic [UPC_W-1:0] LBL_FIN_NO  = 4'd12;
  localparam logic [UPC_W-1:0] LBL_FIN_YES = 4'd13;

  localparam ucode_word_t UCODE_NOP = '{COND_NEXT, LBL_START, RD_LAST, IDX_HOLD,
                                        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, WR_NONE, FIN_NONE};

  localparam ucode_word_t UCODE [UCODE_DEPTH] = '{
    // start: budget and length check, load last digit
    '{COND_SKIP, LBL_FIN_NO, RD_LAST, IDX_LAST,
      1'b0, 1'b1, 1'b0, 1'b0, 1'b0, WR_NONE, FIN_NONE},
    // scan for rightmost rise
    '{COND_IDX_ZERO, LBL_FIN_NO, RD_LAST, IDX_HOLD,
      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, WR_NONE, FIN_NONE},
    '{COND_NOT_RISE, LBL_SCAN, RD_IDX_M1, IDX_DEC,
      1'b1, 1'b1, 1'b1, 1'b0, 1'b0, WR_NONE, FIN_NONE},
    // find rightmost larger suffix digit
    '{COND_NEXT, LBL_START, RD_LAST, IDX_LAST,
      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, WR_NONE, FIN_NONE},
    '{COND_GT, LBL_SWAP, RD_IDX, IDX_HOLD,
      1'b0, 1'b1, 1'b0, 1'b0, 1'b0, WR_NONE, FIN_NONE},
    '{COND_ALWAYS, LBL_FIND, RD_IDX, IDX_DEC,
      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, WR_NONE, FIN_NONE},
    // swap pivot with it
    '{COND_NEXT, LBL_START, RD_LAST, IDX_HOLD,
      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, WR_IDX_A, FIN_NONE},
    '{COND_NEXT, LBL_START, RD_LAST, IDX_HOLD,
      1'b0, 1'b0, 1'b0, 1'b1, 1'b0, WR_PIV_B, FIN_NONE},
    // reverse suffix
    '{COND_LO_GE_HI, LBL_FIN_YES, RD_LAST, IDX_HOLD,
      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, WR_NONE, FIN_NONE},
    '{COND_NEXT, LBL_START, RD_LO, IDX_HOLD,
      1'b1, 1'b0, 1'b0, 1'b0, 1'b0, WR_NONE, FIN_NONE},
    '{COND_NEXT, LBL_START, RD_HI, IDX_HOLD,
      1'b0, 1'b1, 1'b0, 1'b0, 1'b0, WR_HI_A, FIN_NONE},
    '{COND_ALWAYS, LBL_REV, RD_LAST, IDX_HOLD,
      1'b0, 1'b0, 1'b0, 1'b0, 1'b1, WR_LO_B, FIN_NONE},
    // finish
    '{COND_NEXT, LBL_START, RD_LAST, IDX_HOLD,
      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, WR_NONE, FIN_NO},
    '{COND_NEXT, LBL_START, RD_LAST, IDX_HOLD,
      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, WR_NONE, FIN_YES}
  };

endpackage

// File: design/nps_sequencer.sv
`timescale 1ns / 1ps

module nps_sequencer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                out_free,
  input  nps_pkg::cond_flags_t flags,
  output nps_pkg::ucode_word_t uw,
  output logic                fin_fire,
  output logic                busy
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } seq_state_t;

  seq_state_t                   state_r, state_nxt;
  logic [nps_pkg::UPC_W-1:0]    upc_r, upc_nxt;
  nps_pkg::ucode_word_t         rom_word;
  logic                         take;

  assign rom_word = nps_pkg::UCODE[upc_r];
  assign busy     = (state_r == ST_RUN);
  assign uw       = busy ? rom_word : nps_pkg::UCODE_NOP;

  always_comb begin
    unique case (rom_word.cond)
      nps_pkg::COND_NEXT:     take = 1'b0;
      nps_pkg::COND_ALWAYS:   take = 1'b1;
      nps_pkg::COND_SKIP:     take = flags.skip;
      nps_pkg::COND_IDX_ZERO: take = flags.idx_zero;
      nps_pkg::COND_NOT_RISE: take = flags.not_rise;
      nps_pkg::COND_GT:       take = flags.gt;
      nps_pkg::COND_LO_GE_HI: take = flags.lo_ge_hi;
      default:                take = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    upc_nxt   = upc_r;
    fin_fire  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_RUN;
          upc_nxt   = nps_pkg::LBL_START;
        end
      end
      ST_RUN: begin
        if (rom_word.fin != nps_pkg::FIN_NONE) begin
          if (out_free) begin
            fin_fire  = 1'b1;
            state_nxt = ST_IDLE;
            upc_nxt   = nps_pkg::LBL_START;
          end
        end else if (take) begin
          upc_nxt = rom_word.target;
        end else begin
          upc_nxt = upc_r + nps_pkg::UPC_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        upc_nxt   = nps_pkg::LBL_START;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      upc_r   <= nps_pkg::LBL_START;
    end else begin
      state_r <= state_nxt;
      upc_r   <= upc_nxt;
    end
  end

`include "next_permutation_stepper_core_assert.svh"

  `NPS_ASSERT_THEN(a_start_idle, start, state_r == ST_IDLE, "start while running")
  `NPS_ASSERT_NEXT(a_start_run, start, busy && upc_r == nps_pkg::LBL_START, "start not taken")
  `NPS_ASSERT_NEXT(a_fin_idle, fin_fire, state_r == ST_IDLE, "no return to idle after finish")
  `NPS_ASSERT_THEN(a_upc_range, busy, upc_r <= nps_pkg::LBL_FIN_YES, "step counter out of program")

endmodule

// File: design/nps_datapath.sv
`timescale 1ns / 1ps

module nps_datapath #(
  parameter int MAX_DIGITS = 10
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  nps_pkg::ucode_word_t               uw,
  input  logic                               fin_fire,
  input  nps_pkg::load_req_t                 ld,
  input  logic [nps_pkg::STEP_W-1:0]         max_steps,
  output nps_pkg::cond_flags_t               flags,
  output logic [nps_pkg::PACK_W-1:0]         perm_packed,
  output logic [nps_pkg::TOTAL_W-1:0]        digit_total
);

  localparam int IDX_W = $clog2(MAX_DIGITS);
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DIGITS);
  localparam logic [CNT_W-1:0] MIN_CNT = CNT_W'(2);

  logic [nps_pkg::DIGIT_W-1:0] store_r [MAX_DIGITS];
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [nps_pkg::STEP_W-1:0]  steps_r, steps_nxt;
  logic [IDX_W-1:0]            idx_r, idx_nxt;
  logic [IDX_W-1:0]            piv_r, piv_nxt;
  logic [IDX_W-1:0]            lo_r, lo_nxt;
  logic [IDX_W-1:0]            hi_r, hi_nxt;
  logic [nps_pkg::DIGIT_W-1:0] a_r, a_nxt;
  logic [nps_pkg::DIGIT_W-1:0] b_r, b_nxt;

  logic [CNT_W-1:0]            cnt_m1;
  logic [IDX_W-1:0]            last_idx;
  logic [IDX_W-1:0]            rd_addr;
  logic [nps_pkg::DIGIT_W-1:0] rd_data;
  logic [CNT_W-1:0]            ld_base;
  logic                        wr_en;
  logic [IDX_W-1:0]            wr_addr;
  logic [nps_pkg::DIGIT_W-1:0] wr_data;
  logic [31:0]                 cnt_ext;

  assign cnt_m1   = cnt_r - CNT_W'(1);
  assign last_idx = cnt_m1[IDX_W-1:0];

  always_comb begin
    unique case (uw.rd_sel)
      nps_pkg::RD_LAST:   rd_addr = last_idx;
      nps_pkg::RD_IDX_M1: rd_addr = idx_r - IDX_W'(1);
      nps_pkg::RD_IDX:    rd_addr = idx_r;
      nps_pkg::RD_LO:     rd_addr = lo_r;
      nps_pkg::RD_HI:     rd_addr = hi_r;
      default:            rd_addr = last_idx;
    endcase
  end

  assign rd_data = (CNT_W'(rd_addr) < MAX_CNT) ? store_r[rd_addr] : '0;

  assign flags.skip     = (steps_r >= max_steps) || (cnt_r < MIN_CNT);
  assign flags.idx_zero = (idx_r == '0);
  assign flags.not_rise = !(rd_data < b_r);
  assign flags.gt       = (rd_data > a_r);
  assign flags.lo_ge_hi = (lo_r >= hi_r);

  always_comb begin
    ld_base   = ld.first ? '0 : cnt_r;
    cnt_nxt   = cnt_r;
    steps_nxt = steps_r;
    wr_en     = 1'b0;
    wr_addr   = idx_r;
    wr_data   = a_r;
    if (ld.en) begin
      if (ld.first) begin
        steps_nxt = '0;
      end
      cnt_nxt = ld_base;
      if (ld_base < MAX_CNT) begin
        wr_en   = 1'b1;
        wr_addr = ld_base[IDX_W-1:0];
        wr_data = ld.digit;
        cnt_nxt = ld_base + CNT_W'(1);
      end
    end else begin
      unique case (uw.wr_sel)
        nps_pkg::WR_NONE:  wr_en = 1'b0;
        nps_pkg::WR_IDX_A: begin
          wr_en   = 1'b1;
          wr_addr = idx_r;
          wr_data = a_r;
        end
        nps_pkg::WR_PIV_B: begin
          wr_en   = 1'b1;
          wr_addr = piv_r;
          wr_data = b_r;
        end
        nps_pkg::WR_HI_A: begin
          wr_en   = 1'b1;
          wr_addr = hi_r;
          wr_data = a_r;
        end
        nps_pkg::WR_LO_B: begin
          wr_en   = 1'b1;
          wr_addr = lo_r;
          wr_data = b_r;
        end
        default:           wr_en = 1'b0;
      endcase
      if (fin_fire && uw.fin == nps_pkg::FIN_YES) begin
        steps_nxt = steps_r + nps_pkg::STEP_W'(1);
      end
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    unique case (uw.idx_op)
      nps_pkg::IDX_HOLD: idx_nxt = idx_r;
      nps_pkg::IDX_LAST: idx_nxt = last_idx;
      nps_pkg::IDX_DEC:  idx_nxt = idx_r - IDX_W'(1);
      default:           idx_nxt = idx_r;
    endcase
    a_nxt   = uw.load_a   ? rd_data : a_r;
    b_nxt   = uw.load_b   ? rd_data : b_r;
    piv_nxt = uw.load_piv ? idx_r - IDX_W'(1) : piv_r;
    lo_nxt  = lo_r;
    hi_nxt  = hi_r;
    if (uw.init_lohi) begin
      lo_nxt = piv_r + IDX_W'(1);
      hi_nxt = last_idx;
    end else if (uw.step_lohi) begin
      lo_nxt = lo_r + IDX_W'(1);
      hi_nxt = hi_r - IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_addr] <= wr_data;
    end
    idx_r <= idx_nxt;
    piv_r <= piv_nxt;
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      steps_r <= '0;
    end else begin
      cnt_r   <= cnt_nxt;
      steps_r <= steps_nxt;
    end
  end

  for (genvar i = 0; i < nps_pkg::PACK_DIGITS; i++) begin : g_pack
    if (i < MAX_DIGITS) begin : g_held
      assign perm_packed[i*nps_pkg::DIGIT_W +: nps_pkg::DIGIT_W] =
        (CNT_W'(i) < cnt_r) ? store_r[i] : '0;
    end else begin : g_empty
      assign perm_packed[i*nps_pkg::DIGIT_W +: nps_pkg::DIGIT_W] = '0;
    end
  end

  assign cnt_ext     = 32'(cnt_r);
  assign digit_total = cnt_ext[nps_pkg::TOTAL_W-1:0];

`include "next_permutation_stepper_core_assert.svh"

  `NPS_ASSERT_THEN(a_cnt_range, 1'b1, cnt_r <= MAX_CNT, "digit count above capacity")
  `NPS_ASSERT_THEN(a_step_budget, fin_fire && uw.fin == nps_pkg::FIN_YES,
                   steps_r < max_steps, "step taken beyond budget")

endmodule

// File: design/next_permutation_stepper_core.sv
`timescale 1ns / 1ps
// Channel   Ports                                     Payload
// input     in_valid, in_stall, in_data               nps_pkg::in_item_t
// result    out_valid, out_stall, out_data            nps_pkg::out_item_t
// config    psel, penable, pwrite, paddr, pwdata,     max_steps at byte 0
//           prdata, pready
// A load transfer does not stall the input; the block takes the next item right after it.
// An advance runs a 14-word microprogram over one store read and one write per cycle:
// it checks budget and length, scans for the pivot, finds the larger suffix digit,
// swaps the pair and reverses the suffix; in_stall is high while it runs.
// A finished result waits in the output register; the program holds on its last word
// while out_stall blocks that register. rst_n is synchronous and clears counts and budget.

module next_permutation_stepper_core #(
  parameter int MAX_DIGITS = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  nps_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output nps_pkg::out_item_t             out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [nps_pkg::CFG_AW-1:0]     paddr,
  input  logic [nps_pkg::CFG_DW-1:0]     pwdata,
  output logic [nps_pkg::CFG_DW-1:0]     prdata,
  output logic                           pready
);

  logic                          busy;
  logic                          in_xfer;
  logic                          start;
  logic                          out_free;
  logic                          fin_fire;
  nps_pkg::ucode_word_t          uw;
  nps_pkg::cond_flags_t          flags;
  nps_pkg::load_req_t            ld;
  logic [nps_pkg::PACK_W-1:0]    perm_packed;
  logic [nps_pkg::TOTAL_W-1:0]   digit_total;
  logic [nps_pkg::STEP_W-1:0]    max_steps_r, max_steps_nxt;
  logic                          reg_hit;
  logic                          out_valid_r, out_valid_nxt;
  nps_pkg::out_item_t            out_data_r;

  assign in_stall = busy;
  assign in_xfer  = in_valid && !busy;
  assign start    = in_xfer && (in_data.action == nps_pkg::ACTION_ADVANCE);
  assign ld.en    = in_xfer && (in_data.action == nps_pkg::ACTION_LOAD);
  assign ld.first = in_data.first_digit;
  assign ld.digit = in_data.digit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[nps_pkg::CFG_AW-1:2] == nps_pkg::REG_MAX_STEPS);
  assign prdata  = reg_hit ? nps_pkg::CFG_DW'(max_steps_r) : '0;

  always_comb begin
    max_steps_nxt = max_steps_r;
    if (psel && penable && pwrite && pready && reg_hit) begin
      max_steps_nxt = pwdata[nps_pkg::STEP_W-1:0];
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (fin_fire) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_steps_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      max_steps_r <= max_steps_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_fire) begin
      out_data_r.stepped            <= (uw.fin == nps_pkg::FIN_YES);
      out_data_r.permutation_packed <= perm_packed;
      out_data_r.digit_total        <= digit_total;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  nps_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .out_free (out_free),
    .flags    (flags),
    .uw       (uw),
    .fin_fire (fin_fire),
    .busy     (busy)
  );

  nps_datapath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .uw          (uw),
    .fin_fire    (fin_fire),
    .ld          (ld),
    .max_steps   (max_steps_r),
    .flags       (flags),
    .perm_packed (perm_packed),
    .digit_total (digit_total)
  );

endmodule

// File: sim/next_permutation_stepper_core_tb.sv
`timescale 1ns / 1ps

module next_permutation_stepper_core_tb;

  localparam int NUM_DIGITS    = 10;
  localparam int SETTLE_CYCLES = 100;
  localparam int QUIET_LIMIT   = 3000;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASES        = 5;
  localparam int PHASE_ITEMS   = 165;
  localparam logic [nps_pkg::STEP_W-1:0] BUDGET_TOP = 22'd3628800;
  localparam logic ACT_LOAD = nps_pkg::ACTION_LOAD;
  localparam logic ACT_ADV  = nps_pkg::ACTION_ADVANCE;

  typedef enum logic [1:0] {
    ROW_BUDGET,
    ROW_PREDICT,
    ROW_TYPED
  } row_kind_e;

  typedef struct packed {
    row_kind_e                  kind;
    logic [nps_pkg::STEP_W-1:0] budget;
    nps_pkg::in_item_t          item;
    nps_pkg::out_item_t         res;
  } stim_row_t;

  localparam logic [nps_pkg::STEP_W-1:0] NO_BUDGET = '0;
  localparam nps_pkg::out_item_t NO_RES = '0;

  localparam int ROWS = 27;
  localparam stim_row_t DIRECTED [ROWS] = '{
    '{ROW_TYPED,   NO_BUDGET,  '{ACT_ADV,  4'd0, 1'b0}, '{1'b0, 40'h0, 4'd0}},
    '{ROW_PREDICT, NO_BUDGET,  '{ACT_LOAD, 4'd5, 1'b1}, NO_RES},
    '{ROW_TYPED,   NO_BUDGET,  '{ACT_ADV,  4'd0, 1'b0}, '{1'b0, 40'h5, 4'd1}},
    '{ROW_PREDICT, NO_BUDGET,  '{ACT_LOAD, 4'd3, 1'b0}, NO_RES},
    '{ROW_TYPED,   NO_BUDGET,  '{ACT_ADV,  4'd0, 1'b0}, '{1'b0, 40'h35, 4'd2}},
    '{ROW_BUDGET,  BUDGET_TOP, '{ACT_LOAD, 4'd0, 1'b0}, NO_RES},
    '{ROW_PREDICT, NO_BUDGET,  '{ACT_ADV,  4'd9, 1'b1}, NO_RES},
    '{ROW_PREDICT, NO_BUDGET,  '{ACT_LOAD, 4'd9, 1'b1}, NO_RES},
    '{ROW_PREDICT, NO_BUDGET,  '{ACT_LOAD, 4'd8, 1'b0}, NO_RES},
    '{ROW_PREDICT, NO_BUDGET,  '{ACT_LOAD, 4'd7, 1'b0}, NO_RES},
    '{ROW_PREDICT, NO_BUDGET,  '{ACT_LOAD, 4'd6, 1'b0}, NO_RES},
    '{ROW_PREDICT, NO_BUDGET,  '{ACT_LOAD, 4'd5, 1'b0}, NO_RES},
    '{ROW_PREDICT, NO_BUDGET,  '{ACT_LOAD, 4'd4, 1'b0}, NO_RES},
    '{ROW_PREDICT, NO_BUDGET,  '{ACT_LOAD, 4'd3, 1'b0}, NO_RES},
    '{ROW_PREDICT, NO_BUDGET,  '{ACT_LOAD, 4'd2, 1'b0}, NO_RES},
    '{ROW_PREDICT, NO_BUDGET,  '{ACT_LOAD, 4'd1, 1'b0}, NO_RES},
    '{ROW_PREDICT, NO_BUDGET,  '{ACT_LOAD, 4'd0, 1'b0}, NO_RES},
    '{ROW_PREDICT, NO_BUDGET,  '{ACT_LOAD, 4'd5, 1'b0}, NO_RES},
    '{ROW_TYPED,   NO_BUDGET,  '{ACT_ADV,  4'd0, 1'b0}, '{1'b0, 40'h0123456789, 4'd10}},
    '{ROW_PREDICT, NO_BUDGET,  '{ACT_LOAD, 4'd3, 1'b1}, NO_RES},
    '{ROW_PREDICT, NO_BUDGET,  '{ACT_LOAD, 4'd3, 1'b0}, NO_RES},
    '{ROW_TYPED,   NO_BUDGET,  '{ACT_ADV,  4'd0, 1'b0}, '{1'b0, 40'h33, 4'd2}},
    '{ROW_BUDGET,  22'd1,      '{ACT_LOAD, 4'd0, 1'b0}, NO_RES},
    '{ROW_PREDICT, NO_BUDGET,  '{ACT_LOAD, 4'd1, 1'b1}, NO_RES},
    '{ROW_PREDICT, NO_BUDGET,  '{ACT_LOAD, 4'd2, 1'b0}, NO_RES},
    '{ROW_TYPED,   NO_BUDGET,  '{ACT_ADV,  4'd0, 1'b0}, '{1'b1, 40'h12, 4'd2}},
    '{ROW_TYPED,   NO_BUDGET,  '{ACT_ADV,  4'd0, 1'b0}, '{1'b0, 40'h12, 4'd2}}
  };

  logic                        clk       = 1'b0;
  logic                        rst_n     = 1'b0;
  logic                        in_valid  = 1'b0;
  logic                        in_stall;
  nps_pkg::in_item_t           in_data   = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  nps_pkg::out_item_t          out_data;
  logic                        psel      = 1'b0;
  logic                        penable   = 1'b0;
  logic                        pwrite    = 1'b0;
  logic [nps_pkg::CFG_AW-1:0]  paddr     = '0;
  logic [nps_pkg::CFG_DW-1:0]  pwdata    = '0;
  logic [nps_pkg::CFG_DW-1:0]  prdata;
  logic                        pready;

  logic                        row_typed  = 1'b0;
  nps_pkg::out_item_t          row_expect = '0;
  logic                        idle_on    = 1'b1;
  logic                        hold_req   = 1'b0;
  int                          mismatches = 0;
  int                          quiet_cycles = 0;

  logic [3:0]                  digit_mem [NUM_DIGITS] = '{default: '0};
  logic [3:0]                  digit_len   = '0;
  logic [nps_pkg::STEP_W-1:0]  steps_taken = '0;
  logic [nps_pkg::STEP_W-1:0]  step_budget = '0;
  nps_pkg::out_item_t          expected_perms [$];

  next_permutation_stepper_core #(
    .MAX_DIGITS(NUM_DIGITS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic advance_digits();
    int n, p, j, lo, hi;
    logic [3:0] t;
    n = int'(digit_len);
    if (n < 2) return 1'b0;
    p = n - 1;
    while (p > 0 && !(digit_mem[p-1] < digit_mem[p])) p--;
    if (p == 0) return 1'b0;
    j = n - 1;
    while (!(digit_mem[j] > digit_mem[p-1])) j--;
    t = digit_mem[p-1];
    digit_mem[p-1] = digit_mem[j];
    digit_mem[j] = t;
    lo = p;
    hi = n - 1;
    while (lo < hi) begin
      t = digit_mem[lo];
      digit_mem[lo] = digit_mem[hi];
      digit_mem[hi] = t;
      lo++;
      hi--;
    end
    return 1'b1;
  endfunction

  function automatic logic predict_perm(input nps_pkg::in_item_t item,
                                        output nps_pkg::out_item_t res);
    int i;
    logic moved;
    res = '0;
    if (item.action == ACT_LOAD) begin
      if (item.first_digit) begin
        digit_len = '0;
        steps_taken = '0;
      end
      if (digit_len < NUM_DIGITS) begin
        digit_mem[digit_len] = item.digit;
        digit_len++;
      end
      return 1'b0;
    end
    moved = 1'b0;
    if (steps_taken < step_budget && advance_digits()) begin
      steps_taken++;
      moved = 1'b1;
    end
    res.stepped = moved;
    for (i = 0; i < int'(digit_len); i++) res.permutation_packed[4*i +: 4] = digit_mem[i];
    res.digit_total = digit_len;
    return 1'b1;
  endfunction

  always @(posedge clk) begin : track_items
    nps_pkg::out_item_t res;
    if (rst_n && in_valid && !in_stall) begin
      if (predict_perm(in_data, res)) expected_perms.push_back(row_typed ? row_expect : res);
    end
  end

  always @(posedge clk) begin : check_perms
    nps_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_perms.size() == 0) begin
        $error("unexpected result transfer: %h", out_data);
        mismatches++;
      end else begin
        want = expected_perms.pop_front();
        if (out_data.stepped !== want.stepped) begin
          $error("stepped: expected %0d, got %0d", want.stepped, out_data.stepped);
          mismatches++;
        end
        if (out_data.permutation_packed !== want.permutation_packed) begin
          $error("permutation_packed: expected %h, got %h",
                 want.permutation_packed, out_data.permutation_packed);
          mismatches++;
        end
        if (out_data.digit_total !== want.digit_total) begin
          $error("digit_total: expected %0d, got %0d", want.digit_total, out_data.digit_total);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : result_backpressure
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  task automatic send_item(input nps_pkg::in_item_t item, input logic typed,
                           input nps_pkg::out_item_t res);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_data    <= item;
    row_typed  <= typed;
    row_expect <= res;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic set_budget(input logic [nps_pkg::STEP_W-1:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_perms.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {nps_pkg::REG_MAX_STEPS, 2'b00};
    pwdata  <= nps_pkg::CFG_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    step_budget = value;
  endtask

  task automatic send_sequence(output int count);
    logic [3:0] pool [NUM_DIGITS];
    logic [3:0] t;
    int i, j, len, pick, runs;
    logic repeats;
    nps_pkg::in_item_t item;
    pick = $urandom_range(0, 9);
    if (pick < 5) len = $urandom_range(2, 4);
    else if (pick < 8) len = $urandom_range(5, 7);
    else if (pick == 8) len = $urandom_range(8, 10);
    else if ($urandom_range(0, 1) == 0) len = $urandom_range(0, 1);
    else len = $urandom_range(11, 12);
    for (i = 0; i < NUM_DIGITS; i++) pool[i] = 4'(i);
    for (i = NUM_DIGITS - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = pool[i];
      pool[i] = pool[j];
      pool[j] = t;
    end
    repeats = ($urandom_range(0, 3) == 0);
    for (i = 0; i < len; i++) begin
      item.action = ACT_LOAD;
      item.digit = (repeats || i >= NUM_DIGITS) ? 4'($urandom_range(0, 9)) : pool[i];
      item.first_digit = (i == 0) && ($urandom_range(0, 7) != 0);
      send_item(item, 1'b0, NO_RES);
    end
    runs = $urandom_range(1, 24);
    for (i = 0; i < runs; i++) begin
      item.action = ACT_ADV;
      item.digit = 4'($urandom_range(0, 9));
      item.first_digit = 1'($urandom_range(0, 1));
      send_item(item, 1'b0, NO_RES);
    end
    count = len + runs;
  endtask

  initial begin : stimulus
    int r, ph, sent, got;
    nps_pkg::in_item_t item;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (r = 0; r < ROWS; r++) begin
      if (DIRECTED[r].kind == ROW_BUDGET) set_budget(DIRECTED[r].budget);
      else send_item(DIRECTED[r].item, DIRECTED[r].kind == ROW_TYPED, DIRECTED[r].res);
    end

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: set_budget(BUDGET_TOP);
        1: set_budget(nps_pkg::STEP_W'($urandom_range(1, 30)));
        2: set_budget(NO_BUDGET);
        3: set_budget(nps_pkg::STEP_W'($urandom_range(2, 6)));
        default: set_budget(BUDGET_TOP);
      endcase
      if (ph == 1) hold_req = 1'b1;
      if (ph == PHASES - 1) idle_on = 1'b0;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 5) == 0) begin
          item.action = 1'($urandom_range(0, 1));
          item.digit = 4'($urandom_range(0, 9));
          item.first_digit = 1'($urandom_range(0, 1));
          send_item(item, 1'b0, NO_RES);
          sent++;
        end else begin
          send_sequence(got);
          sent += got;
        end
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_perms.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
